[design/dme_pkg.sv]
// Shared widths, handoff type and Morse pattern functions for the decimal Morse encoder.
package dme_pkg;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned PAT_W      = 20;
  localparam int unsigned LEN_W      = 5;
  localparam int unsigned MAX_DIGITS = 10;
  localparam int unsigned DEC_DIGITS = 10;
  localparam int unsigned LIMIT      = (MAX_DIGITS < DEC_DIGITS) ? MAX_DIGITS : DEC_DIGITS;
  localparam int unsigned BCD_W      = DEC_DIGITS * DIGIT_W;
  localparam int unsigned CNT_W      = $clog2(VALUE_W + 1);
  localparam int unsigned IDX_W      = $clog2(DEC_DIGITS);

  typedef struct packed {
    logic             vld;
    logic [BCD_W-1:0] bcd;
  } bcd_xfer_t;

  function automatic logic [PAT_W-1:0] morse_pattern(logic [DIGIT_W-1:0] d);
    logic [PAT_W-1:0] pat;
    logic [LEN_W-1:0] pos;
    logic             dash;
    pat = '0;
    pos = '0;
    for (int i = 0; i < 5; i++) begin
      if (d <= DIGIT_W'(5)) begin
        dash = (DIGIT_W'(i) >= d);
      end else begin
        dash = (DIGIT_W'(i) < (d - DIGIT_W'(5)));
      end
      if (dash) begin
        pat = pat | (PAT_W'(7) << pos);
        pos = pos + LEN_W'(4);
      end else begin
        pat = pat | (PAT_W'(1) << pos);
        pos = pos + LEN_W'(2);
      end
    end
    return pat;
  endfunction

  // Five elements: 2 units per dot, 4 per dash.
  function automatic logic [LEN_W-1:0] morse_length(logic [DIGIT_W-1:0] d);
    logic [LEN_W-1:0] dd;
    dd = {d, 1'b0};
    if (d <= DIGIT_W'(5)) begin
      return LEN_W'(20) - dd;
    end
    return dd;
  endfunction

endpackage

[design/dme_bcd.sv]
// Bit-serial binary to BCD converter (shift and add-3), one input bit per cycle.
module dme_bcd (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [dme_pkg::VALUE_W-1:0]  value_i,
  output dme_pkg::bcd_xfer_t           res_o,
  input  logic                         res_ack_i
);
  import dme_pkg::*;

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [VALUE_W-1:0] sh_q, sh_d;
  logic [BCD_W-1:0]   bcd_q, bcd_d;
  logic [BCD_W-1:0]   adj;
  logic               accept;

  assign in_stall_o = busy_q | done_q;
  assign accept     = in_valid_i & ~in_stall_o;
  assign res_o.vld  = done_q;
  assign res_o.bcd  = bcd_q;

  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (bcd_q[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
        adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
      end else begin
        adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    sh_d   = sh_q;
    bcd_d  = bcd_q;
    if (accept) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(VALUE_W);
      sh_d   = value_i;
      bcd_d  = '0;
    end else if (busy_q) begin
      bcd_d = {adj[BCD_W-2:0], sh_q[VALUE_W-1]};
      sh_d  = {sh_q[VALUE_W-2:0], 1'b0};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (done_q && res_ack_i) begin
      done_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    bcd_q <= bcd_d;
  end

endmodule

[design/dme_emit.sv]
// Digit sequencer: walks the BCD digits from the top and registers one Morse result per transfer.
module dme_emit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  dme_pkg::bcd_xfer_t           res_i,
  output logic                         res_ack_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [dme_pkg::DIGIT_W-1:0]  digit_o,
  output logic [dme_pkg::PAT_W-1:0]    pattern_o,
  output logic [dme_pkg::LEN_W-1:0]    pattern_length_o,
  output logic                         last_digit_o
);
  import dme_pkg::*;

  logic               busy_q;
  logic [BCD_W-1:0]   digits_q;
  logic [IDX_W-1:0]   idx_q;
  logic [IDX_W-1:0]   start;
  logic               vld_q;
  logic [DIGIT_W-1:0] dig_q;
  logic [PAT_W-1:0]   pat_q;
  logic [LEN_W-1:0]   len_q;
  logic               last_q;
  logic [DIGIT_W-1:0] cur;
  logic               emit;

  assign res_ack_o = res_i.vld & ~busy_q;
  assign emit      = busy_q & (~vld_q | ~out_stall_i);
  assign cur       = digits_q[{idx_q, 2'b00} +: DIGIT_W];

  // Highest nonzero kept digit; zero value starts at digit 0.
  always_comb begin
    start = '0;
    for (int i = 0; i < LIMIT; i++) begin
      if (res_i.bcd[i*DIGIT_W +: DIGIT_W] != '0) begin
        start = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      vld_q  <= 1'b0;
      idx_q  <= '0;
    end else begin
      if (res_ack_o) begin
        busy_q <= 1'b1;
        idx_q  <= start;
      end else if (emit) begin
        idx_q <= idx_q - IDX_W'(1);
        if (idx_q == '0) begin
          busy_q <= 1'b0;
        end
      end
      if (emit) begin
        vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ack_o) begin
      digits_q <= res_i.bcd;
    end
    if (emit) begin
      dig_q  <= cur;
      pat_q  <= morse_pattern(cur);
      len_q  <= morse_length(cur);
      last_q <= (idx_q == '0);
    end
  end

  assign out_valid_o      = vld_q;
  assign digit_o          = dig_q;
  assign pattern_o        = pat_q;
  assign pattern_length_o = len_q;
  assign last_digit_o     = last_q;

endmodule

[design/decimal_morse_digit_encoder.sv]
// Top level of the decimal Morse digit encoder.
// A 32-bit unsigned value is turned into decimal digits, most significant first with leading
// zeros dropped (zero gives one digit 0), and each digit leaves as one transfer carrying its
// Morse keying pattern (bit 0 first, dot = on/off, dash = three on/one off), its length in
// units and a flag on the final digit. A value occupies the bit-serial BCD converter for its
// load, one shift per input bit and the handoff of the digits to the sequencer. The first
// digit can transfer once the sequencer has registered it in its output register, and the
// rest follow at up to one per cycle from that register while the receiver does not stall.
// The converter takes the next value while the previous one's digits are still being sent,
// so with no output stalls the converter is the limit on sustained rate.
module decimal_morse_digit_encoder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [dme_pkg::VALUE_W-1:0]  value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [dme_pkg::DIGIT_W-1:0]  digit_o,
  output logic [dme_pkg::PAT_W-1:0]    pattern_o,
  output logic [dme_pkg::LEN_W-1:0]    pattern_length_o,
  output logic                         last_digit_o
);
  import dme_pkg::*;

  bcd_xfer_t res;
  logic      res_ack;

  dme_bcd u_bcd (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .value_i    (value_i),
    .res_o      (res),
    .res_ack_i  (res_ack)
  );

  dme_emit u_emit (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .res_i            (res),
    .res_ack_o        (res_ack),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .digit_o          (digit_o),
    .pattern_o        (pattern_o),
    .pattern_length_o (pattern_length_o),
    .last_digit_o     (last_digit_o)
  );

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// Testbench for the decimal Morse digit encoder: directed and random values, checked per digit.
module tb_top;
  import dme_pkg::*;

  localparam int unsigned RESET_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned RANDOM_ITEMS = 72;
  localparam int unsigned REPORT_MAX   = 10;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic [PAT_W-1:0]   pattern;
    logic [LEN_W-1:0]   plen;
    logic               last;
  } morse_digit_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [VALUE_W-1:0] value;
  logic               out_valid;
  logic               out_stall;
  logic [DIGIT_W-1:0] digit;
  logic [PAT_W-1:0]   pattern;
  logic [LEN_W-1:0]   pattern_length;
  logic               last_digit;

  morse_digit_t expected_digits[$];
  int unsigned  send_idle_pct;
  int unsigned  stall_pct;
  int unsigned  values_sent;
  int unsigned  digits_checked;
  int unsigned  error_count;
  int unsigned  cycle_count;

  decimal_morse_digit_encoder dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .value_i          (value),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .digit_o          (digit),
    .pattern_o        (pattern),
    .pattern_length_o (pattern_length),
    .last_digit_o     (last_digit)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d digits outstanding", cycle_count,
               expected_digits.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic void note_error(string msg);
    error_count++;
    if (error_count <= REPORT_MAX) begin
      $display("ERROR at %0t: %s", $realtime, msg);
    end
  endfunction

  // Dot is one unit on, one off; dash is three on, one off; bit 0 goes first.
  function automatic morse_digit_t encode_digit(logic [DIGIT_W-1:0] d, logic last);
    morse_digit_t r;
    int unsigned  pos;
    logic         dash;
    r.digit   = d;
    r.pattern = '0;
    r.last    = last;
    pos       = 0;
    for (int i = 0; i < 5; i++) begin
      if (d <= 5) begin
        dash = (i >= d);
      end else begin
        dash = (i < d - 5);
      end
      r.pattern = r.pattern | ((dash ? PAT_W'(7) : PAT_W'(1)) << pos);
      pos += dash ? 4 : 2;
    end
    r.plen = LEN_W'(pos);
    return r;
  endfunction

  task automatic predict_digits(logic [VALUE_W-1:0] v);
    logic [DIGIT_W-1:0] lsd_first[$];
    logic [VALUE_W-1:0] rest;
    int unsigned        keep;
    rest = v;
    do begin
      lsd_first.push_back(DIGIT_W'(rest % 10));
      rest = rest / 10;
    end while (rest != 0);
    keep = (MAX_DIGITS < 1) ? 1 : MAX_DIGITS;
    while (lsd_first.size() > keep) lsd_first.pop_back();
    for (int k = lsd_first.size() - 1; k >= 0; k--) begin
      expected_digits.push_back(encode_digit(lsd_first[k], k == 0));
    end
  endtask

  task automatic send_value(logic [VALUE_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_digits(v);
    values_sent++;
  endtask

  // Receiver: random stall, in-order compare of every digit transfer.
  always @(posedge clk) begin
    morse_digit_t got;
    morse_digit_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
      if (out_valid && !out_stall) begin
        got = '{digit, pattern, pattern_length, last_digit};
        if (expected_digits.size() == 0) begin
          note_error($sformatf(
            "unexpected digit transfer: digit %0d pattern %05h len %0d last %0b",
            got.digit, got.pattern, got.plen, got.last));
        end else begin
          want = expected_digits.pop_front();
          digits_checked++;
          if (got !== want) begin
            note_error($sformatf(
              {"digit exp %0d got %0d, pattern exp %05h got %05h, ",
               "len exp %0d got %0d, last exp %0b got %0b"},
              want.digit, got.digit, want.pattern, got.pattern, want.plen, got.plen,
              want.last, got.last));
          end
        end
      end
    end
  end

  task automatic test_directed_values();
    logic [VALUE_W-1:0] vals[] = '{
      32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd7, 32'd8, 32'd9,
      32'd10, 32'd99, 32'd100, 32'd1234567890, 32'd1000000000, 32'd1000000001,
      32'd999999999, 32'd4294967295, 32'd4000000000, 32'h8000_0000,
      32'h5555_5555, 32'hAAAA_AAAA
    };
    send_idle_pct = 0;
    stall_pct     = 0;
    foreach (vals[i]) send_value(vals[i]);
  endtask

  task automatic test_random_values(int unsigned idle_pct, int unsigned stall_pct_arg);
    logic [VALUE_W-1:0] v;
    int unsigned        span;
    send_idle_pct = idle_pct;
    stall_pct     = stall_pct_arg;
    repeat (RANDOM_ITEMS) begin
      case ($urandom_range(3))
        0: v = $urandom();
        1: v = $urandom() >> $urandom_range(31);
        default: begin
          span = 1;
          repeat ($urandom_range(9, 1)) span = span * 10;
          v = $urandom_range(span - 1, 0);
        end
      endcase
      send_value(v);
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    value          = '0;
    send_idle_pct  = 0;
    stall_pct      = 0;
    values_sent    = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_values();
    test_random_values(0, 0);
    test_random_values(64, 0);
    test_random_values(0, 64);
    test_random_values(27, 27);
    in_valid <= 1'b0;

    while (expected_digits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_digits.size() != 0) begin
      note_error($sformatf("%0d digits never arrived", expected_digits.size()));
    end

    $display("Encoded %0d values (zero, single digits, ten-digit extremes, random widths)",
             values_sent);
    $display("Checked %0d digit transfers under sender gaps and receiver stalls, %0d errors",
             digits_checked, error_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
